FILE: hw/rtl/wsb_pkg.sv
// Wheel speed balancer package: sequencer state type, CSR indexes and request codes.
// No dependencies; used by wheel_speed_balancer.
`default_nettype none

package wsb_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DELTA,
      ST_RATIO,
      ST_MUL,
      ST_OVER,
      ST_SUM,
      ST_CLAMP,
      ST_DIV,
      ST_DONE
   } state_type;

   localparam int CSR_IDX_BITS = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_PWM      = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_PWM      = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LEFT_TARGET  = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RIGHT_TARGET = 2'd3;

   localparam logic REQ_BEGIN  = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   // Reset value of the upper drive limit, truncated to the drive width.
   localparam int MAX_PWM_RESET = 1023;

   // Fraction bits of the speed ratio and its output width.
   localparam int RATIO_FRAC_BITS = 8;
   localparam int RATIO_BITS      = 16;

endpackage

`default_nettype wire

FILE: hw/rtl/wheel_speed_balancer.sv
// Wheel speed balancer: sequencer plus one shared add/subtract unit for all products and quotients.
// Depends on wsb_pkg.
`default_nettype none

// Balances two wheel drive values from encoder samples. A begin item loads the start drive into
// both wheels and clears the encoder baselines; a sample item forms the tick deltas, and when the
// smaller delta is nonzero rescales both drives by the speed ratio, moves overshoot of one wheel to
// the other and clamps both to [min_pwm, max_pwm]. Items are handled one at a time through a single
// adder that does restoring division and shift-add multiplication one bit per cycle. A begin item
// goes from acceptance straight to completion, a sample with a zero delta through the delta step
// to completion, and an adjusting sample through the deltas, the ratio division, the four
// products, overshoot, sums, then for each wheel a range check and, when in range, a final
// truncating division, and completion. Completion also waits while the previous result is
// uncollected. req_ready is high only while the sequencer is idle; a finished result waits in the
// output register, so the next item can be taken before the previous one is collected.
module wheel_speed_balancer #(
   parameter int PWM_BITS   = 10,
   parameter int COUNT_BITS = 16,
   localparam int CSR_BITS  = (PWM_BITS > COUNT_BITS) ? PWM_BITS : COUNT_BITS
) (
   input  wire                                  clock,
   input  wire                                  reset,

   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire                                  req_type,
   input  wire  [PWM_BITS-1:0]                  req_start_pwm,
   input  wire  [COUNT_BITS-1:0]                req_left_count,
   input  wire  [COUNT_BITS-1:0]                req_right_count,

   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [PWM_BITS-1:0]                  rsp_left_drive,
   output logic [PWM_BITS-1:0]                  rsp_right_drive,
   output logic [wsb_pkg::RATIO_BITS-1:0]       rsp_speed_ratio,
   output logic                                 rsp_adjusted,
   output logic                                 rsp_move_done,

   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [wsb_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire  [CSR_BITS-1:0]                  csr_wdata
);

   localparam int P   = PWM_BITS;
   localparam int C   = COUNT_BITS;
   localparam int RB  = wsb_pkg::RATIO_BITS;
   localparam int XW  = P + C + 4;                       // scaled drive values, signed
   localparam int FW  = C + 3;                           // scale factors, signed
   localparam int AW  = XW + 1;                          // shared adder
   localparam int QW  = C + wsb_pkg::RATIO_FRAC_BITS;    // ratio quotient
   localparam int SW  = XW;                              // operand bit shifter
   localparam int RW  = C + 1;                           // division remainder
   localparam int CW  = $clog2(QW);

   // state and configuration
   wsb_pkg::state_type state_ff, state_in;
   logic [P-1:0]  min_pwm_ff, min_pwm_in, max_pwm_ff, max_pwm_in;
   logic [C-1:0]  left_target_ff, left_target_in, right_target_ff, right_target_in;
   logic [C-1:0]  base_left_ff, base_left_in, base_right_ff, base_right_in;
   logic [P-1:0]  drive_left_ff, drive_left_in, drive_right_ff, drive_right_in;

   // item working registers
   logic [C-1:0]  lc_ff, lc_in, rc_ff, rc_in;
   logic [C-1:0]  mx_ff, mx_in, mn_ff, mn_in;
   logic          left_fast_ff, left_fast_in;
   logic signed [FW-1:0] fl_ff, fl_in, fr_ff, fr_in;
   logic [SW-1:0] sh_ff, sh_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [QW-1:0] q_ff, q_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]    mi_ff, mi_in;
   logic signed [XW-1:0] acc_ff, acc_in;
   logic signed [XW-1:0] xp_ff [4];
   logic signed [XW-1:0] xp_in [4];
   logic signed [XW-1:0] ol_ff, ol_in, or_ff, or_in;
   logic signed [XW-1:0] yl_ff, yl_in, yr_ff, yr_in;
   logic          ws_ff, ws_in;
   logic [RB-1:0] ratio_ff, ratio_in;
   logic          adj_ff, adj_in, done_ff, done_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [P-1:0]  rsp_left_ff, rsp_left_in, rsp_right_ff, rsp_right_in;
   logic [RB-1:0] rsp_ratio_ff, rsp_ratio_in;
   logic          rsp_adj_ff, rsp_adj_in, rsp_done_ff, rsp_done_in;

   // shared adder
   logic signed [AW-1:0] alu_a, alu_b, alu_out;
   logic                 alu_sub;
   logic [RW-1:0]        divisor;
   logic signed [FW-1:0] mcand;
   logic signed [FW-1:0] dscale;

   // combinational helpers
   logic [C-1:0]     dl, dr;
   logic             gt;
   logic [RW:0]      shifted;
   logic             qbit;
   logic [QW-1:0]    q_next;
   logic [QW+RB-1:0] q_wide;
   logic [P-1:0]     mplier_next;
   logic signed [FW-1:0] f_sub, f_add;
   logic signed [XW-1:0] y_sel, lod, hid;

   assign dscale  = {2'b00, mn_ff, 1'b0};
   assign divisor = (state_ff == wsb_pkg::ST_RATIO) ? {1'b0, mn_ff} : {mn_ff, 1'b0};

   always_comb begin
      case (mi_ff)
         2'd0:    mcand = fl_ff;
         2'd1:    mcand = fr_ff;
         default: mcand = dscale;
      endcase
   end

   // operand selection for the shared unit
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         wsb_pkg::ST_RATIO, wsb_pkg::ST_DIV: begin
            alu_a   = {{(AW-RW-1){1'b0}}, rem_ff, sh_ff[SW-1]};
            alu_b   = {{(AW-RW){1'b0}}, divisor};
            alu_sub = 1'b1;
         end
         wsb_pkg::ST_MUL: begin
            alu_a = {acc_ff, 1'b0};
            alu_b = sh_ff[SW-1] ? {{(AW-FW){mcand[FW-1]}}, mcand} : '0;
         end
         default: begin
            alu_sub = 1'b0;
         end
      endcase
   end

   assign alu_out = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

   assign dl      = lc_ff - base_left_ff;
   assign dr      = rc_ff - base_right_ff;
   assign gt      = dl > dr;
   assign shifted = {rem_ff, sh_ff[SW-1]};
   assign qbit    = !alu_out[AW-1];
   assign q_next  = {q_ff[QW-2:0], qbit};
   assign q_wide  = {{RB{1'b0}}, q_next};
   assign f_sub   = {3'b000, mn_ff} + {2'b00, mn_ff, 1'b0} - {3'b000, mx_ff};
   assign f_add   = {3'b000, mn_ff} + {3'b000, mx_ff};
   assign y_sel   = ws_ff ? yr_ff : yl_ff;
   assign lod     = xp_ff[2];
   assign hid     = xp_ff[3];

   always_comb begin
      case (mi_ff)
         2'd0:    mplier_next = drive_right_ff;
         2'd1:    mplier_next = min_pwm_ff;
         default: mplier_next = max_pwm_ff;
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      min_pwm_in      = min_pwm_ff;
      max_pwm_in      = max_pwm_ff;
      left_target_in  = left_target_ff;
      right_target_in = right_target_ff;
      base_left_in    = base_left_ff;
      base_right_in   = base_right_ff;
      drive_left_in   = drive_left_ff;
      drive_right_in  = drive_right_ff;
      lc_in           = lc_ff;
      rc_in           = rc_ff;
      mx_in           = mx_ff;
      mn_in           = mn_ff;
      left_fast_in    = left_fast_ff;
      fl_in           = fl_ff;
      fr_in           = fr_ff;
      sh_in           = sh_ff;
      rem_in          = rem_ff;
      q_in            = q_ff;
      cnt_in          = cnt_ff;
      mi_in           = mi_ff;
      acc_in          = acc_ff;
      xp_in           = xp_ff;
      ol_in           = ol_ff;
      or_in           = or_ff;
      yl_in           = yl_ff;
      yr_in           = yr_ff;
      ws_in           = ws_ff;
      ratio_in        = ratio_ff;
      adj_in          = adj_ff;
      done_in         = done_ff;
      rsp_left_in     = rsp_left_ff;
      rsp_right_in    = rsp_right_ff;
      rsp_ratio_in    = rsp_ratio_ff;
      rsp_adj_in      = rsp_adj_ff;
      rsp_done_in     = rsp_done_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;

      if (csr_valid) begin
         case (csr_index)
            wsb_pkg::CSR_MIN_PWM:      min_pwm_in      = csr_wdata[P-1:0];
            wsb_pkg::CSR_MAX_PWM:      max_pwm_in      = csr_wdata[P-1:0];
            wsb_pkg::CSR_LEFT_TARGET:  left_target_in  = csr_wdata[C-1:0];
            wsb_pkg::CSR_RIGHT_TARGET: right_target_in = csr_wdata[C-1:0];
            default:                   min_pwm_in      = min_pwm_ff;
         endcase
      end

      case (state_ff)
         wsb_pkg::ST_IDLE: begin
            if (req_valid) begin
               lc_in = req_left_count;
               rc_in = req_right_count;
               if (req_type == wsb_pkg::REQ_BEGIN) begin
                  drive_left_in  = req_start_pwm;
                  drive_right_in = req_start_pwm;
                  base_left_in   = '0;
                  base_right_in  = '0;
                  done_in        = (left_target_ff == '0) && (right_target_ff == '0);
                  adj_in         = 1'b0;
                  ratio_in       = '0;
                  state_in       = wsb_pkg::ST_DONE;
               end else begin
                  state_in = wsb_pkg::ST_DELTA;
               end
            end
         end

         wsb_pkg::ST_DELTA: begin
            mx_in        = gt ? dl : dr;
            mn_in        = gt ? dr : dl;
            left_fast_in = gt;
            done_in      = (lc_ff >= left_target_ff) && (rc_ff >= right_target_ff);
            ratio_in     = '0;
            adj_in       = 1'b0;
            if ((gt ? dr : dl) == '0) begin
               state_in = wsb_pkg::ST_DONE;
            end else begin
               adj_in        = 1'b1;
               base_left_in  = lc_ff;
               base_right_in = rc_ff;
               rem_in        = '0;
               q_in          = '0;
               sh_in         = {(gt ? dl : dr), {wsb_pkg::RATIO_FRAC_BITS{1'b0}},
                                {(SW-QW){1'b0}}};
               cnt_in        = CW'(QW-1);
               state_in      = wsb_pkg::ST_RATIO;
            end
         end

         wsb_pkg::ST_RATIO: begin
            // one quotient bit of (max << 8) / min per cycle
            rem_in = qbit ? alu_out[RW-1:0] : shifted[RW-1:0];
            q_in   = q_next;
            sh_in  = sh_ff << 1;
            cnt_in = cnt_ff - CW'(1);
            fl_in  = left_fast_ff ? f_sub : f_add;
            fr_in  = left_fast_ff ? f_add : f_sub;
            if (cnt_ff == '0) begin
               ratio_in = (|q_wide[QW+RB-1:RB]) ? {RB{1'b1}} : q_next[RB-1:0];
               sh_in    = {drive_left_ff, {(SW-P){1'b0}}};
               acc_in   = '0;
               mi_in    = 2'd0;
               cnt_in   = CW'(P-1);
               state_in = wsb_pkg::ST_MUL;
            end
         end

         wsb_pkg::ST_MUL: begin
            // products: left drive, right drive, min*D, max*D; multiplier MSB first
            acc_in = alu_out[XW-1:0];
            sh_in  = sh_ff << 1;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               xp_in[mi_ff] = alu_out[XW-1:0];
               acc_in       = '0;
               if (mi_ff == 2'd3) begin
                  state_in = wsb_pkg::ST_OVER;
               end else begin
                  mi_in  = mi_ff + 2'd1;
                  sh_in  = {mplier_next, {(SW-P){1'b0}}};
                  cnt_in = CW'(P-1);
               end
            end
         end

         wsb_pkg::ST_OVER: begin
            if (xp_ff[0] < lod) begin
               ol_in = lod - xp_ff[0];
            end else if (xp_ff[0] > hid) begin
               ol_in = hid - xp_ff[0];
            end else begin
               ol_in = '0;
            end
            if (xp_ff[1] < lod) begin
               or_in = lod - xp_ff[1];
            end else if (xp_ff[1] > hid) begin
               or_in = hid - xp_ff[1];
            end else begin
               or_in = '0;
            end
            state_in = wsb_pkg::ST_SUM;
         end

         wsb_pkg::ST_SUM: begin
            // each wheel takes the other wheel's overshoot
            yl_in    = xp_ff[0] + or_ff;
            yr_in    = xp_ff[1] + ol_ff;
            ws_in    = 1'b0;
            state_in = wsb_pkg::ST_CLAMP;
         end

         wsb_pkg::ST_CLAMP: begin
            if ((y_sel < lod) || (y_sel > hid)) begin
               if (ws_ff) begin
                  drive_right_in = (y_sel < lod) ? min_pwm_ff : max_pwm_ff;
                  state_in       = wsb_pkg::ST_DONE;
               end else begin
                  drive_left_in = (y_sel < lod) ? min_pwm_ff : max_pwm_ff;
                  ws_in         = 1'b1;
               end
            end else begin
               // in range: quotient fits the drive width, so start with the upper bits
               rem_in   = y_sel[P+RW-1:P];
               sh_in    = {y_sel[P-1:0], {(SW-P){1'b0}}};
               q_in     = '0;
               cnt_in   = CW'(P-1);
               state_in = wsb_pkg::ST_DIV;
            end
         end

         wsb_pkg::ST_DIV: begin
            rem_in = qbit ? alu_out[RW-1:0] : shifted[RW-1:0];
            q_in   = q_next;
            sh_in  = sh_ff << 1;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               if (ws_ff) begin
                  drive_right_in = q_next[P-1:0];
                  state_in       = wsb_pkg::ST_DONE;
               end else begin
                  drive_left_in = q_next[P-1:0];
                  ws_in         = 1'b1;
                  state_in      = wsb_pkg::ST_CLAMP;
               end
            end
         end

         wsb_pkg::ST_DONE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = drive_left_ff;
               rsp_right_in = drive_right_ff;
               rsp_ratio_in = ratio_ff;
               rsp_adj_in   = adj_ff;
               rsp_done_in  = done_ff;
               state_in     = wsb_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = wsb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= wsb_pkg::ST_IDLE;
         min_pwm_ff      <= '0;
         max_pwm_ff      <= P'(wsb_pkg::MAX_PWM_RESET);
         left_target_ff  <= '0;
         right_target_ff <= '0;
         base_left_ff    <= '0;
         base_right_ff   <= '0;
         drive_left_ff   <= '0;
         drive_right_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         min_pwm_ff      <= min_pwm_in;
         max_pwm_ff      <= max_pwm_in;
         left_target_ff  <= left_target_in;
         right_target_ff <= right_target_in;
         base_left_ff    <= base_left_in;
         base_right_ff   <= base_right_in;
         drive_left_ff   <= drive_left_in;
         drive_right_ff  <= drive_right_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lc_ff        <= lc_in;
      rc_ff        <= rc_in;
      mx_ff        <= mx_in;
      mn_ff        <= mn_in;
      left_fast_ff <= left_fast_in;
      fl_ff        <= fl_in;
      fr_ff        <= fr_in;
      sh_ff        <= sh_in;
      rem_ff       <= rem_in;
      q_ff         <= q_in;
      cnt_ff       <= cnt_in;
      mi_ff        <= mi_in;
      acc_ff       <= acc_in;
      xp_ff        <= xp_in;
      ol_ff        <= ol_in;
      or_ff        <= or_in;
      yl_ff        <= yl_in;
      yr_ff        <= yr_in;
      ws_ff        <= ws_in;
      ratio_ff     <= ratio_in;
      adj_ff       <= adj_in;
      done_ff      <= done_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_ratio_ff <= rsp_ratio_in;
      rsp_adj_ff   <= rsp_adj_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign req_ready       = (state_ff == wsb_pkg::ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_drive  = rsp_left_ff;
   assign rsp_right_drive = rsp_right_ff;
   assign rsp_speed_ratio = rsp_ratio_ff;
   assign rsp_adjusted    = rsp_adj_ff;
   assign rsp_move_done   = rsp_done_ff;

   a_ratio_at_least_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_adjusted |-> rsp_speed_ratio >= RB'(256))
      else $error("adjusted item with speed ratio below one");

   a_ratio_zero_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_adjusted |-> rsp_speed_ratio == '0)
      else $error("unadjusted item with nonzero speed ratio");

   a_drives_in_limits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_adjusted && (min_pwm_ff <= max_pwm_ff) |->
         (rsp_left_drive >= min_pwm_ff) && (rsp_left_drive <= max_pwm_ff) &&
         (rsp_right_drive >= min_pwm_ff) && (rsp_right_drive <= max_pwm_ff))
      else $error("adjusted drive outside the configured limits");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == wsb_pkg::ST_DONE)
      else $error("result raised outside the completion step");

endmodule

`default_nettype wire
